// ===== design/fbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types and constants of the frustum box containment block: plane
// count, stored plane layout, operation and containment codes, state type.
// ----------------------------------------------------------------------------
package fbc_pkg;

   // number of stored frustum planes
   localparam int NUM_PLANES = 6;
   // address width of the plane memory
   localparam int PLANE_AW   = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
   // width of a counter that reaches NUM_PLANES itself
   localparam int CNT_W      = $clog2(NUM_PLANES + 1);
   // width of the exact Q32.32 distance sum
   localparam int SUM_W      = 66;

   typedef logic signed [31:0] coord_type;

   // one stored plane: normal (a, b, c) and offset d, all Q16.16
   typedef struct packed {
      coord_type a;
      coord_type b;
      coord_type c;
      coord_type d;
   } plane_type;

   typedef logic [0:0] op_type;
   localparam op_type OP_WRITE = 1'b0;
   localparam op_type OP_TEST  = 1'b1;

   typedef logic [1:0] cont_type;
   localparam cont_type CONT_DISJOINT   = 2'd0;
   localparam cont_type CONT_INTERSECTS = 2'd1;
   localparam cont_type CONT_CONTAINS   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } fbc_state_type;

endpackage

// ===== design/fbc_req_if.sv =====
// ----------------------------------------------------------------------------
// fbc_req_if
// Request channel: one plane write or one box test per transfer.
// ----------------------------------------------------------------------------
interface fbc_req_if;
   import fbc_pkg::*;

   logic                valid;
   logic                ready;
   op_type              operation;
   logic [2:0]          plane_index;
   coord_type           plane_a;
   coord_type           plane_b;
   coord_type           plane_c;
   coord_type           plane_d;
   coord_type           box_min_x;
   coord_type           box_min_y;
   coord_type           box_min_z;
   coord_type           box_max_x;
   coord_type           box_max_y;
   coord_type           box_max_z;

   modport source (
      output valid, operation, plane_index, plane_a, plane_b, plane_c, plane_d,
             box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      input  ready
   );

   modport sink (
      input  valid, operation, plane_index, plane_a, plane_b, plane_c, plane_d,
             box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      output ready
   );

endinterface

// ===== design/fbc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fbc_rsp_if
// Response channel: one containment code per box test.
// ----------------------------------------------------------------------------
interface fbc_rsp_if;
   import fbc_pkg::*;

   logic     valid;
   logic     ready;
   cont_type containment;

   modport source (
      output valid, containment,
      input  ready
   );

   modport sink (
      input  valid, containment,
      output ready
   );

endinterface

// ===== design/frustum_box_containment.sv =====
// ----------------------------------------------------------------------------
// frustum_box_containment
// Frustum versus axis-aligned box test over a small plane memory.
// ----------------------------------------------------------------------------
// The block holds NUM_PLANES planes (normal and offset, Q16.16) in a plane
// memory that reads as all zero after reset. A write request stores one plane
// in the cycle of its transfer and gives no response; an index at or above
// NUM_PLANES is dropped. A test request walks all planes through a three-stage
// path (memory read, six signed 32x32 products, exact 66-bit distance sums)
// and returns disjoint, intersects or contains. A test occupies the block from
// its transfer until the next request can be transferred: planes are read one
// per cycle through the single read port of the plane memory, the product and
// sum stages drain, the flags settle and the response is loaded once the
// output register is free. The response sits in that output register, so a
// new request is taken while a finished response still waits.
// ----------------------------------------------------------------------------
module frustum_box_containment (
   input  logic       clock,
   input  logic       reset,
   fbc_req_if.sink    req_if,
   fbc_rsp_if.source  rsp_if
);
   import fbc_pkg::*;

   fbc_state_type          state_ff, state_in;
   logic                   req_fire;
   logic                   start_test;
   logic                   do_write;
   logic                   running;
   logic                   issue;
   logic                   rsp_load;

   // plane memory and per-entry valid bits
   plane_type              plane_mem [NUM_PLANES];
   logic [NUM_PLANES-1:0]  ent_vld_ff;
   logic [PLANE_AW-1:0]    wr_addr;
   logic [PLANE_AW-1:0]    rd_addr;

   // box corners of the test in flight
   coord_type              box_min_x_ff, box_min_y_ff, box_min_z_ff;
   coord_type              box_max_x_ff, box_max_y_ff, box_max_z_ff;

   // read issue counter
   logic [CNT_W-1:0]       iss_ff, iss_in;

   // stage 1: memory data
   logic                   s1_vld_ff, s1_last_ff;
   plane_type              rd_data_ff;
   logic                   rd_ent_vld_ff;
   plane_type              eff_plane;

   // stage 2: products
   logic                   s2_vld_ff, s2_last_ff;
   coord_type              far_x, far_y, far_z, near_x, near_y, near_z;
   logic signed [63:0]     far_x_prod_ff, far_y_prod_ff, far_z_prod_ff;
   logic signed [63:0]     near_x_prod_ff, near_y_prod_ff, near_z_prod_ff;
   coord_type              offset_ff;

   // stage 3: distance signs and accumulated flags
   logic signed [SUM_W-1:0] offset_term;
   logic signed [SUM_W-1:0] far_sum, near_sum;
   logic                   far_behind_ff, far_behind_in;
   logic                   near_behind_ff, near_behind_in;

   // response register
   logic                   rsp_valid_ff;
   cont_type               rsp_cont_ff;

   assign req_fire   = req_if.valid && req_if.ready;
   assign start_test = req_fire && (req_if.operation == OP_TEST);
   assign do_write   = req_fire && (req_if.operation == OP_WRITE) &&
                       (int'(req_if.plane_index) < NUM_PLANES);
   assign wr_addr    = PLANE_AW'(req_if.plane_index);
   assign rd_addr    = iss_ff[PLANE_AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_test) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (s2_vld_ff && s2_last_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_if.ready = 1'b0;
      running      = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_if.ready = 1'b1;
         ST_RUN:  running      = 1'b1;
         ST_DONE: rsp_load     = !rsp_valid_ff || rsp_if.ready;
         default: req_if.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // write one plane on a write transfer
   always_ff @(posedge clock) begin
      if (do_write) begin
         plane_mem[wr_addr] <= '{a: req_if.plane_a, b: req_if.plane_b,
                                 c: req_if.plane_c, d: req_if.plane_d};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= '0;
      end else if (do_write) begin
         ent_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // capture the box on a test transfer
   always_ff @(posedge clock) begin
      if (start_test) begin
         box_min_x_ff <= req_if.box_min_x;
         box_min_y_ff <= req_if.box_min_y;
         box_min_z_ff <= req_if.box_min_z;
         box_max_x_ff <= req_if.box_max_x;
         box_max_y_ff <= req_if.box_max_y;
         box_max_z_ff <= req_if.box_max_z;
      end
   end

   // advance the read issue counter, one plane per cycle
   assign issue = running && (iss_ff != CNT_W'(NUM_PLANES));

   always_comb begin
      iss_in = iss_ff;
      if (start_test) begin
         iss_in = '0;
      end else if (issue) begin
         iss_in = iss_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff <= '0;
      end else begin
         iss_ff <= iss_in;
      end
   end

   // stage 1: synchronous memory read
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff    <= plane_mem[rd_addr];
         rd_ent_vld_ff <= ent_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s1_last_ff <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s2_last_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= issue;
         s1_last_ff <= issue && (iss_ff == CNT_W'(NUM_PLANES - 1));
         s2_vld_ff  <= s1_vld_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // stage 2: pick far and near corners, form the products
   assign eff_plane = rd_ent_vld_ff ? rd_data_ff : '0;

   always_comb begin
      far_x  = (eff_plane.a > 0) ? box_max_x_ff : box_min_x_ff;
      near_x = (eff_plane.a > 0) ? box_min_x_ff : box_max_x_ff;
      far_y  = (eff_plane.b > 0) ? box_max_y_ff : box_min_y_ff;
      near_y = (eff_plane.b > 0) ? box_min_y_ff : box_max_y_ff;
      far_z  = (eff_plane.c > 0) ? box_max_z_ff : box_min_z_ff;
      near_z = (eff_plane.c > 0) ? box_min_z_ff : box_max_z_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         far_x_prod_ff  <= eff_plane.a * far_x;
         far_y_prod_ff  <= eff_plane.b * far_y;
         far_z_prod_ff  <= eff_plane.c * far_z;
         near_x_prod_ff <= eff_plane.a * near_x;
         near_y_prod_ff <= eff_plane.b * near_y;
         near_z_prod_ff <= eff_plane.c * near_z;
         offset_ff      <= eff_plane.d;
      end
   end

   // stage 3: exact Q32.32 distances, keep only the signs
   assign offset_term = $signed({{(SUM_W - 48){offset_ff[31]}}, offset_ff, 16'h0000});
   assign far_sum     = SUM_W'(far_x_prod_ff) + SUM_W'(far_y_prod_ff) +
                        SUM_W'(far_z_prod_ff) + offset_term;
   assign near_sum    = SUM_W'(near_x_prod_ff) + SUM_W'(near_y_prod_ff) +
                        SUM_W'(near_z_prod_ff) + offset_term;

   always_comb begin
      far_behind_in  = far_behind_ff;
      near_behind_in = near_behind_ff;
      if (start_test) begin
         far_behind_in  = 1'b0;
         near_behind_in = 1'b0;
      end else if (s2_vld_ff) begin
         far_behind_in  = far_behind_ff  | far_sum[SUM_W-1];
         near_behind_in = near_behind_ff | near_sum[SUM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         far_behind_ff  <= 1'b0;
         near_behind_ff <= 1'b0;
      end else begin
         far_behind_ff  <= far_behind_in;
         near_behind_ff <= near_behind_in;
      end
   end

   // response register: load when free or drained in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (far_behind_ff) begin
            rsp_cont_ff <= CONT_DISJOINT;
         end else if (near_behind_ff) begin
            rsp_cont_ff <= CONT_INTERSECTS;
         end else begin
            rsp_cont_ff <= CONT_CONTAINS;
         end
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.containment = rsp_cont_ff;

`ifndef NO_ASSERTIONS
   // pipeline stages only carry work while a test runs
   a_stages_in_run: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff || s2_vld_ff) |-> (state_ff == ST_RUN))
      else $error("plane pipeline busy outside a test");

   // issue counter never passes the plane count
   a_iss_range: assert property (@(posedge clock) disable iff (reset)
      iss_ff <= CNT_W'(NUM_PLANES))
      else $error("read issue counter out of range");

   // a new response appears only out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response loaded outside done state");

   // reaching done means the last plane just went through stage 3
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && s2_vld_ff && s2_last_ff) |=> (state_ff == ST_DONE))
      else $error("test did not complete after last plane");

   // a waiting response carries a defined code
   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_cont_ff == CONT_DISJOINT ||
                        rsp_cont_ff == CONT_INTERSECTS ||
                        rsp_cont_ff == CONT_CONTAINS))
      else $error("undefined containment code");
`endif

endmodule

// ===== tb/tb_frustum_box_containment.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frustum_box_containment
// Self-checking bench for the frustum versus axis-aligned box test.
// ----------------------------------------------------------------------------
// A behavioral plane store mirrors every accepted plane write, and each
// accepted box test pushes its predicted containment code (exact signed
// distance of the far and near corner against all planes) into an in-order
// queue. A checker pops that queue on every response transfer and compares
// the code. Directed tests cover the untouched store, single-plane cases,
// out-of-range plane writes, zero normal components, inverted boxes and
// full-scale values; random traffic then mixes plane write bursts followed by
// box tests with noise items, under varying request and response idling and
// one long response stall.
// ----------------------------------------------------------------------------
module tb_frustum_box_containment;
   import fbc_pkg::*;

   localparam int        LIMIT_CYCLES = 250000;
   localparam int        LONG_STALL   = 300;
   localparam int        DRAIN_CYCLES = 4 * (NUM_PLANES + 3);
   localparam int        DIST_W       = 70;
   localparam coord_type COORD_MIN    = 32'sh8000_0000;
   localparam coord_type COORD_MAX    = 32'sh7fff_ffff;
   localparam coord_type Q_ONE        = 32'sh0001_0000;

   // one request as the bench sees it
   typedef struct packed {
      op_type     operation;
      logic [2:0] plane_index;
      plane_type  plane;
      coord_type  min_x;
      coord_type  min_y;
      coord_type  min_z;
      coord_type  max_x;
      coord_type  max_y;
      coord_type  max_z;
   } fbc_item_type;

   logic clock;
   logic reset;

   fbc_req_if req_bus ();
   fbc_rsp_if rsp_bus ();

   frustum_box_containment DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   plane_type plane_store [NUM_PLANES];
   cont_type  expected_containment [$];
   int        mismatch_count;
   int        cycle_count;
   int        req_idle_max;
   int        rsp_idle_max;
   int        stall_requests;

   // generate clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // stop a hung run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic int draw_gap(input int max_gap);
      return (max_gap == 0) ? 0 : int'($urandom_range(max_gap, 0));
   endfunction

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // exact Q32.32 signed distance of a point to a plane, sign only
   function automatic logic lies_behind(input plane_type pl, input coord_type x,
                                        input coord_type y, input coord_type z);
      coord_type               a;
      coord_type               b;
      coord_type               c;
      coord_type               d;
      logic signed [DIST_W-1:0] signed_dist;
      a           = pl.a;
      b           = pl.b;
      c           = pl.c;
      d           = pl.d;
      signed_dist = a * x;
      signed_dist = signed_dist + b * y;
      signed_dist = signed_dist + c * z;
      signed_dist = signed_dist + (d <<< 16);
      return signed_dist < 0;
   endfunction

   function automatic cont_type predict_containment(input fbc_item_type item);
      plane_type pl;
      coord_type na;
      coord_type nb;
      coord_type nc;
      coord_type fx, fy, fz;
      coord_type nx, ny, nz;
      logic      cut;
      cut = 1'b0;
      for (int p = 0; p < NUM_PLANES; p++) begin
         pl = plane_store[p];
         na = pl.a;
         nb = pl.b;
         nc = pl.c;
         // far corner along the normal, zero counts as not positive
         fx = (na > 0) ? item.max_x : item.min_x;
         nx = (na > 0) ? item.min_x : item.max_x;
         fy = (nb > 0) ? item.max_y : item.min_y;
         ny = (nb > 0) ? item.min_y : item.max_y;
         fz = (nc > 0) ? item.max_z : item.min_z;
         nz = (nc > 0) ? item.min_z : item.max_z;
         if (lies_behind(pl, fx, fy, fz))
            return CONT_DISJOINT;
         if (lies_behind(pl, nx, ny, nz))
            cut = 1'b1;
      end
      return cut ? CONT_INTERSECTS : CONT_CONTAINS;
   endfunction

   // update the plane store or queue a prediction for one transfer
   function automatic void apply_transfer(input fbc_item_type item);
      if (item.operation == OP_WRITE) begin
         if (item.plane_index < NUM_PLANES)
            plane_store[item.plane_index] = item.plane;
      end else begin
         expected_containment.push_back(predict_containment(item));
      end
   endfunction

   // ------------------------------------------------------------------------
   // Item builders
   // ------------------------------------------------------------------------

   function automatic coord_type rand_coord();
      case ($urandom_range(7, 0))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return '0;
         3: return -1;
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic coord_type rand_span(input int lo, input int hi);
      return coord_type'(lo + int'($urandom_range(hi - lo, 0)));
   endfunction

   function automatic fbc_item_type make_write(input int idx, input coord_type a,
                                               input coord_type b, input coord_type c,
                                               input coord_type d);
      fbc_item_type item;
      item             = fbc_item_type'({$urandom, $urandom, $urandom, $urandom,
                                         $urandom, $urandom, $urandom, $urandom,
                                         $urandom, $urandom, $urandom});
      item.operation   = OP_WRITE;
      item.plane_index = idx[2:0];
      item.plane.a     = a;
      item.plane.b     = b;
      item.plane.c     = c;
      item.plane.d     = d;
      return item;
   endfunction

   function automatic fbc_item_type make_test(input coord_type lx, input coord_type ly,
                                              input coord_type lz, input coord_type hx,
                                              input coord_type hy, input coord_type hz);
      fbc_item_type item;
      item           = fbc_item_type'({$urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom});
      item.operation = OP_TEST;
      item.min_x     = lx;
      item.min_y     = ly;
      item.min_z     = lz;
      item.max_x     = hx;
      item.max_y     = hy;
      item.max_z     = hz;
      return item;
   endfunction

   // plane of frustum-like scale, with occasional zero or full-scale parts
   function automatic coord_type rand_normal_part();
      case ($urandom_range(9, 0))
         0: return '0;
         1: return rand_coord();
         default: return rand_span(-(1 << 17), 1 << 17);
      endcase
   endfunction

   function automatic fbc_item_type random_plane_write(input int idx);
      coord_type d;
      d = ($urandom_range(9, 0) == 0) ? rand_coord() : rand_span(-(1 << 22), 1 << 24);
      return make_write(idx, rand_normal_part(), rand_normal_part(), rand_normal_part(), d);
   endfunction

   // box near the origin, sometimes inverted, sometimes arbitrary
   function automatic fbc_item_type random_box_test();
      coord_type lo [3];
      coord_type hi [3];
      coord_type ctr;
      coord_type half;
      if ($urandom_range(9, 0) == 0)
         return make_test(rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord());
      for (int ax = 0; ax < 3; ax++) begin
         ctr  = rand_span(-(1 << 21), 1 << 21);
         half = rand_span(0, 1 << 19);
         lo[ax] = ctr - half;
         hi[ax] = ctr + half;
         if ($urandom_range(15, 0) == 0) begin
            lo[ax] = ctr + half;
            hi[ax] = ctr - half;
         end
      end
      return make_test(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endfunction

   function automatic fbc_item_type noise_item();
      fbc_item_type item;
      item             = make_test(rand_coord(), rand_coord(), rand_coord(),
                                   rand_coord(), rand_coord(), rand_coord());
      item.operation   = op_type'($urandom_range(1, 0));
      item.plane_index = 3'($urandom_range(7, 0));
      item.plane.a     = rand_coord();
      item.plane.b     = rand_coord();
      item.plane.c     = rand_coord();
      item.plane.d     = rand_coord();
      return item;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------

   // offer one item after a random gap, return once it has transferred
   task automatic send_item(input fbc_item_type item);
      int gap;
      gap = draw_gap(req_idle_max);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.operation   <= item.operation;
      req_bus.plane_index <= item.plane_index;
      req_bus.plane_a     <= item.plane.a;
      req_bus.plane_b     <= item.plane.b;
      req_bus.plane_c     <= item.plane.c;
      req_bus.plane_d     <= item.plane.d;
      req_bus.box_min_x   <= item.min_x;
      req_bus.box_min_y   <= item.min_y;
      req_bus.box_min_z   <= item.min_z;
      req_bus.box_max_x   <= item.max_x;
      req_bus.box_max_y   <= item.max_y;
      req_bus.box_max_z   <= item.max_z;
      req_bus.valid       <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      apply_transfer(item);
   endtask

   // ------------------------------------------------------------------------
   // Response receiver and checker
   // ------------------------------------------------------------------------

   // draw a ready gap per response, serve long stall requests
   initial begin : rsp_receiver
      int gap;
      int stalls_served;
      rsp_bus.ready = 1'b0;
      stalls_served = 0;
      forever begin
         @(negedge clock);
         if (stalls_served != stall_requests) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_STALL) @(negedge clock);
            stalls_served++;
         end
         gap = draw_gap(rsp_idle_max);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin : rsp_checker
      cont_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_containment.size() == 0) begin
            report_mismatch($sformatf("containment %0d with no test pending",
                                      rsp_bus.containment));
         end else begin
            want = expected_containment.pop_front();
            if (rsp_bus.containment !== want)
               report_mismatch($sformatf("containment got %0d expected %0d",
                                         rsp_bus.containment, want));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // untouched store: every distance is zero, so everything is contained
   task automatic test_reset_state();
      send_item(make_test(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      send_item(make_test(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
   endtask

   // half space x >= 0, then writes past the last plane that must be dropped
   task automatic test_single_plane();
      send_item(make_write(0, Q_ONE, '0, '0, '0));
      send_item(make_test(Q_ONE, -Q_ONE, -Q_ONE, 2 * Q_ONE, Q_ONE, Q_ONE));
      send_item(make_test(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE));
      send_item(make_test(-2 * Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE));
      send_item(make_test('0, -Q_ONE, -Q_ONE, '0, Q_ONE, Q_ONE));
      send_item(make_write(NUM_PLANES, '0, '0, '0, -Q_ONE));
      send_item(make_write(7, '0, '0, '0, COORD_MIN));
      send_item(make_test(Q_ONE, -Q_ONE, -Q_ONE, 2 * Q_ONE, Q_ONE, Q_ONE));
   endtask

   // full-scale planes and boxes, zero normal parts, inverted box
   task automatic test_plane_extremes();
      send_item(make_write(1, COORD_MIN, COORD_MAX, '0, COORD_MAX));
      send_item(make_write(2, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_item(make_write(3, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      send_item(make_write(4, -1, -1, -1, '0));
      send_item(make_write(5, '0, '0, Q_ONE, COORD_MIN));
      send_item(make_test(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      send_item(make_test(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
      send_item(make_test('0, '0, '0, '0, '0, '0));
   endtask

   // plane write bursts followed by box tests, with some noise items
   task automatic test_random_traffic(input int num_items, input int req_max,
                                      input int rsp_max);
      int           sent;
      int           idx;
      fbc_item_type item;
      req_idle_max = req_max;
      rsp_idle_max = rsp_max;
      sent         = 0;
      while (sent < num_items) begin
         if ($urandom_range(9, 0) == 0) begin
            item = noise_item();
            send_item(item);
            if (item.operation == OP_TEST || item.plane_index < NUM_PLANES)
               sent++;
         end else begin
            repeat ($urandom_range(3, 0)) begin
               if ($urandom_range(15, 0) == 0)
                  idx = $urandom_range(7, NUM_PLANES);
               else
                  idx = $urandom_range(NUM_PLANES - 1, 0);
               send_item(random_plane_write(idx));
               if (idx < NUM_PLANES)
                  sent++;
            end
            repeat ($urandom_range(8, 1)) begin
               send_item(random_box_test());
               sent++;
            end
         end
      end
   endtask

   // hold the response side off while tests keep coming back to back
   task automatic test_response_stall();
      req_idle_max = 0;
      rsp_idle_max = 0;
      send_item(random_plane_write($urandom_range(NUM_PLANES - 1, 0)));
      stall_requests++;
      repeat (16) send_item(random_box_test());
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.operation   = OP_WRITE;
      req_bus.plane_index = '0;
      req_bus.plane_a     = '0;
      req_bus.plane_b     = '0;
      req_bus.plane_c     = '0;
      req_bus.plane_d     = '0;
      req_bus.box_min_x   = '0;
      req_bus.box_min_y   = '0;
      req_bus.box_min_z   = '0;
      req_bus.box_max_x   = '0;
      req_bus.box_max_y   = '0;
      req_bus.box_max_z   = '0;
      mismatch_count      = 0;
      req_idle_max        = 0;
      rsp_idle_max        = 0;
      stall_requests      = 0;
      for (int p = 0; p < NUM_PLANES; p++)
         plane_store[p] = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_single_plane();
      test_plane_extremes();
      test_random_traffic(240, 0, 0);
      test_random_traffic(240, 12, 0);
      test_random_traffic(240, 0, 12);
      test_response_stall();
      test_random_traffic(230, 12, 12);

      // drop valid and drain outstanding tests
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_containment.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== frustum_box_containment.f =====
design/fbc_pkg.sv
design/fbc_req_if.sv
design/fbc_rsp_if.sv
design/frustum_box_containment.sv
tb/tb_frustum_box_containment.sv
